>>> hdl/delimited_frame_receiver_unit_macros.svh
// Assertion macros shared by the delimited frame receiver.
`ifndef DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dfr_pkg.sv
// Shared types and constants of the delimited frame receiver.
`default_nettype none

package dfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int PIDX_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;

    // Marker values after reset.
    localparam logic [BYTE_W-1:0] BEGIN_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    // Command queue depth, a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_END,
        CMD_DATA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic overflow;
        logic count_full;
        logic draining;
    } t_back_status;

endpackage

`default_nettype wire

>>> hdl/dfr_front.sv
// Front end: marker registers and classification of each received byte.
`default_nettype none

module dfr_front
    import dfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    input  wire logic                 i_rx_valid,
    output logic                      o_rx_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    logic [BYTE_W-1:0] r_begin_marker;
    logic [BYTE_W-1:0] r_end_marker;

    // Configuration writes are always taken; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_marker <= BEGIN_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BEGIN_MARKER) begin
                r_begin_marker <= i_cfg_data;
            end else if (i_cfg_index == REG_END_MARKER) begin
                r_end_marker <= i_cfg_data;
            end
        end
    end

    // A request enters the queue whenever there is room.
    assign o_rx_stall = i_q_full;
    assign o_push     = i_rx_valid && !i_q_full;

    // The begin marker wins when both markers hold the same value.
    always_comb begin
        o_cmd.data = i_rx_byte;
        priority if (i_rx_byte == r_begin_marker) begin
            o_cmd.kind = CMD_BEGIN;
        end else if (i_rx_byte == r_end_marker) begin
            o_cmd.kind = CMD_END;
        end else begin
            o_cmd.kind = CMD_DATA;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dfr_cmd_queue.sv
// Short command queue between the front end and the frame engine.
`default_nettype none

module dfr_cmd_queue
    import dfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage slots hold payload only.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/dfr_back.sv
// Frame engine: frame store, running checksum and payload drain.
`default_nettype none

module dfr_back
    import dfr_pkg::*;
#(
    parameter int FRAME_CAPACITY = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_pop,
    output logic                   o_pl_valid,
    input  wire logic              i_pl_stall,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic [PIDX_W-1:0]      o_payload_index,
    output logic                   o_last_of_frame,
    output t_back_status           o_status
);

    localparam int IDX_W = $clog2(FRAME_CAPACITY);
    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_open;
    logic               r_overflow;
    logic [BYTE_W-1:0]  r_sum;
    logic [BYTE_W-1:0]  r_last;
    logic [IDX_W-1:0]   r_k;
    logic [IDX_W-1:0]   r_final;
    logic               r_out_valid;
    logic [PIDX_W-1:0]  r_out_index;
    logic               r_out_last;
    logic [BYTE_W-1:0]  r_rd_data;
    logic [BYTE_W-1:0]  r_mem [FRAME_CAPACITY];

    logic               w_full;
    logic               w_pass;
    logic               w_wr_en;
    logic               w_rd_en;

    // The store is full once it holds the capacity.
    assign w_full = (r_count >= CNT_W'(FRAME_CAPACITY));

    // The sum of all stored bytes but the last is kept as bytes arrive.
    assign w_pass = (r_count > CNT_W'(1)) && (r_sum == r_last);

    assign o_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign w_wr_en = o_pop && (i_cmd.kind == CMD_DATA) && r_open && !w_full;
    assign w_rd_en = (r_state == S_READ);

    // Frame store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_cmd.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    // Control state machine and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_open      <= 1'b0;
            r_overflow  <= 1'b0;
            r_k         <= '0;
            r_final     <= '0;
            r_out_valid <= 1'b0;
            r_out_index <= '0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            CMD_BEGIN: begin
                                r_open     <= 1'b1;
                                r_overflow <= 1'b0;
                                r_count    <= '0;
                            end
                            CMD_END: begin
                                r_open <= 1'b0;
                                if (w_pass) begin
                                    r_k     <= '0;
                                    r_final <= IDX_W'(r_count - CNT_W'(2));
                                    r_state <= S_READ;
                                end
                            end
                            CMD_DATA: begin
                                if (r_open) begin
                                    if (w_full) begin
                                        r_overflow <= 1'b1;
                                    end else begin
                                        r_count <= r_count + 1'b1;
                                        r_sum   <= (r_count == '0) ? '0 : r_sum + r_last;
                                        r_last  <= i_cmd.data;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_index <= PIDX_W'(r_k);
                    r_out_last  <= (r_k == r_final);
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_pl_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The running sum and last byte are payload and need no reset.
    assign o_pl_valid      = r_out_valid;
    assign o_payload_byte  = r_rd_data;
    assign o_payload_index = r_out_index;
    assign o_last_of_frame = r_out_last;

    assign o_status.overflow   = r_overflow;
    assign o_status.count_full = w_full;
    assign o_status.draining   = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/delimited_frame_receiver_unit.sv
// Top level of the delimited frame receiver.
//
//  Channel   Direction  Handshake                Contents
//  rx        in         i_rx_valid / o_rx_stall  i_rx_byte
//  payload   out        o_pl_valid / i_pl_stall  o_payload_byte, o_payload_index,
//                                                o_last_of_frame
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A received byte enters a two-entry command queue; the frame engine takes one command
// per cycle while it is idle and none while a frame drains. A passing frame drains each
// payload byte through a read state and an emit state, due to the registered read port
// of the frame store; the queue takes two more bytes meanwhile and then stalls the input.
// Reset is synchronous and active low; it clears the control state and restores the
// markers, while the frame store holds no reset. A stalled payload request holds.
`default_nettype none

`include "delimited_frame_receiver_unit_macros.svh"

module delimited_frame_receiver_unit
    import dfr_pkg::*;
#(
    parameter int FRAME_CAPACITY = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    input  wire logic                 i_rx_valid,
    output logic                      o_rx_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output logic                      o_pl_valid,
    input  wire logic                 i_pl_stall,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic [PIDX_W-1:0]         o_payload_index,
    output logic                      o_last_of_frame
);

    logic         w_q_full;
    logic         w_push;
    t_cmd         w_front_cmd;
    logic         w_q_valid;
    t_cmd         w_q_cmd;
    logic         w_pop;
    t_back_status w_status;

    // Marker registers and byte classification.
    dfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    // Decoupling queue.
    dfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Frame engine.
    dfr_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_pop           (w_pop),
        .o_pl_valid      (o_pl_valid),
        .i_pl_stall      (i_pl_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_last_of_frame (o_last_of_frame),
        .o_status        (w_status)
    );

    // The overflow flag is only ever set with the store at capacity.
    `DFR_ASSERT_NOW(a_overflow_full, i_clk, i_rst_n, w_status.overflow, w_status.count_full, "overflow flag set below capacity")

    // A payload request only appears while a frame is draining.
    `DFR_ASSERT_NOW(a_valid_draining, i_clk, i_rst_n, o_pl_valid, w_status.draining, "payload request outside a drain")

    // After the final byte of a frame is taken, no request follows at once.
    `DFR_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_pl_valid && !i_pl_stall && o_last_of_frame, !o_pl_valid, "payload request right after the final byte")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for the framed byte receiver: table-driven and random frames vs. a decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int STORE_CAP      = 64;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 330;
    localparam int QUIET_AFTER    = 270;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 34;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [PIDX_W-1:0] index;
        logic              last;
    } t_payload_rec;

    typedef enum logic {
        ROW_RX,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    val;
        bit                   typed;
        int                   n_typed;
        t_payload_rec         rec;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 rx_valid;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 pl_stall;
    logic                 o_cfg_ready;
    logic                 o_rx_stall;
    logic                 o_pl_valid;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [PIDX_W-1:0]    o_payload_index;
    logic                 o_last_of_frame;

    // Decoder state kept alongside the block.
    logic [BYTE_W-1:0] mir_begin;
    logic [BYTE_W-1:0] mir_end;
    logic [BYTE_W-1:0] mir_store [STORE_CAP];
    int                mir_count;
    bit                mir_open;
    bit                mir_ovf;

    t_payload_rec decoded_q[$];
    t_payload_rec pending_payload_q[$];

    bit           typed_pending = 1'b0;
    int           typed_n       = 0;
    t_payload_rec typed_rec     = '0;

    int rx_accepted  = 0;
    int results_seen = 0;
    int errors       = 0;
    int gap_odds     = 4;
    int stall_odds   = 4;
    int stall_left   = 0;
    bit no_idle      = 1'b0;

    // Directed frames; a typed row carries the result that it must produce.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{ROW_RX,  '0, 8'h03, 1'b1, 0, '0},
        '{ROW_RX,  '0, 8'h55, 1'b1, 0, '0},
        '{ROW_RX,  '0, 8'h02, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h03, 1'b1, 1, '{8'h00, 6'd0, 1'b1}},
        '{ROW_RX,  '0, 8'h03, 1'b1, 1, '{8'h00, 6'd0, 1'b1}},
        '{ROW_RX,  '0, 8'h02, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'hFF, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h03, 1'b1, 0, '0},
        '{ROW_RX,  '0, 8'h02, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'hFF, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'hFF, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h03, 1'b1, 1, '{8'hFF, 6'd0, 1'b1}},
        '{ROW_RX,  '0, 8'h02, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h10, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h11, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h03, 1'b1, 0, '0},
        '{ROW_RX,  '0, 8'h02, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h80, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h80, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h03, 1'b0, 0, '0},
        '{ROW_CFG, REG_SPARE_2,      8'hAA, 1'b0, 0, '0},
        '{ROW_CFG, REG_SPARE_3,      8'h55, 1'b0, 0, '0},
        '{ROW_CFG, REG_BEGIN_MARKER, 8'h00, 1'b0, 0, '0},
        '{ROW_CFG, REG_END_MARKER,   8'hFF, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h7F, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h7F, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'hFF, 1'b1, 1, '{8'h7F, 6'd0, 1'b1}},
        '{ROW_CFG, REG_END_MARKER,   8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h00, 1'b0, 0, '0},
        '{ROW_RX,  '0, 8'h01, 1'b0, 0, '0}
    };

    delimited_frame_receiver_unit #(
        .FRAME_CAPACITY(STORE_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (rx_byte),
        .o_pl_valid     (o_pl_valid),
        .i_pl_stall     (pl_stall),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_last_of_frame(o_last_of_frame)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decode one received byte; frames that pass the checksum land in decoded_q.
    function automatic void frame_checksum_decode(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        t_payload_rec      rec;
        sum = '0;
        if (b == mir_begin) begin
            mir_open  = 1'b1;
            mir_ovf   = 1'b0;
            mir_count = 0;
        end else if (b == mir_end) begin
            // The count survives the end marker, so a repeat re-checks the old bytes.
            mir_open = 1'b0;
            if (mir_count > 1) begin
                for (int k = 0; k < mir_count - 1; k++) begin
                    sum = sum + mir_store[k];
                end
                if (sum == mir_store[mir_count-1]) begin
                    for (int k = 0; k < mir_count - 1; k++) begin
                        rec.data  = mir_store[k];
                        rec.index = PIDX_W'(k);
                        rec.last  = (k == mir_count - 2);
                        decoded_q.push_back(rec);
                    end
                end
            end
        end else if (mir_open) begin
            if (mir_count >= STORE_CAP) begin
                mir_ovf = 1'b1;
            end else begin
                mir_store[mir_count] = b;
                mir_count++;
            end
        end
    endfunction

    // Random byte that is neither marker.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == mir_begin || b == mir_end) begin
            b = BYTE_W'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // Predict on every accepted byte, check every accepted payload request.
    always @(posedge i_clk) begin
        t_payload_rec got;
        t_payload_rec want;
        if (rst_n) begin
            if (rx_valid && !o_rx_stall) begin
                decoded_q.delete();
                frame_checksum_decode(rx_byte);
                if (typed_pending) begin
                    if (typed_n == 1) begin
                        pending_payload_q.push_back(typed_rec);
                    end
                end else begin
                    foreach (decoded_q[i]) begin
                        pending_payload_q.push_back(decoded_q[i]);
                    end
                end
            end
            if (o_pl_valid && !pl_stall) begin
                results_seen++;
                got = {o_payload_byte, o_payload_index, o_last_of_frame};
                if (pending_payload_q.size() == 0) begin
                    $display("%0t: unexpected payload byte=%h index=%0d last=%b",
                             $time, got.data, got.index, got.last);
                    errors++;
                end else begin
                    want = pending_payload_q.pop_front();
                    if (got.data !== want.data || got.index !== want.index ||
                        got.last !== want.last) begin
                        $display("%0t: payload mismatch expected byte=%h index=%0d last=%b, got byte=%h index=%0d last=%b",
                                 $time, want.data, want.index, want.last,
                                 got.data, got.index, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Payload stall in random bursts of random length.
    always @(negedge i_clk) begin
        if (!rst_n || no_idle || stall_odds == 0) begin
            pl_stall   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            pl_stall   <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(1, stall_odds) == 1) begin
            pl_stall   <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            pl_stall <= 1'b0;
        end
    end

    // Present one byte, possibly after a gap, and wait until it is taken.
    task automatic send_rx(input logic [BYTE_W-1:0] b, input bit typed, input int n,
                           input t_payload_rec rec);
        int gap;
        @(negedge i_clk);
        typed_pending = typed;
        typed_n       = n;
        typed_rec     = rec;
        gap = 0;
        if (!no_idle && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 7);
        end
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        rx_accepted++;
    endtask

    task automatic send_plain(input logic [BYTE_W-1:0] b);
        send_rx(b, 1'b0, 0, '0);
    endtask

    // Let all expected payload drain, then give the block time to go idle.
    task automatic settle();
        @(negedge i_clk);
        rx_valid <= 1'b0;
        while (pending_payload_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write request, issued only once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        settle();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_BEGIN_MARKER) begin
            mir_begin = val;
        end else if (idx == REG_END_MARKER) begin
            mir_end = val;
        end
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One marker setting followed by mostly well-formed frames with random content.
    task automatic run_random_phase(input bit first, input int directed_items);
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] sum;
        int                budget;
        int                start;
        int                kind;
        int                len;
        int                extra;
        bit                long_due;
        long_due = first;
        no_idle  = (rx_accepted - directed_items) >= QUIET_AFTER;
        case (first ? 0 : $urandom_range(0, 7))
            0: begin
                b0 = BEGIN_MARKER_RST;
                b1 = END_MARKER_RST;
            end
            1: begin
                b0 = 8'h00;
                b1 = 8'hFF;
            end
            2: begin
                b0 = 8'hFF;
                b1 = 8'h00;
            end
            3: begin
                b0 = BYTE_W'($urandom_range(0, 255));
                b1 = b0;
            end
            default: begin
                b0 = BYTE_W'($urandom_range(0, 255));
                b1 = BYTE_W'($urandom_range(0, 255));
                while (b1 == b0) b1 = BYTE_W'($urandom_range(0, 255));
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      BYTE_W'($urandom_range(0, 255)));
        end
        write_reg(REG_BEGIN_MARKER, b0);
        write_reg(REG_END_MARKER, b1);
        case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 2;
            default: gap_odds = 5;
        endcase
        case ($urandom_range(0, 2))
            0: stall_odds = 0;
            1: stall_odds = 2;
            default: stall_odds = 5;
        endcase
        budget = $urandom_range(30, 60);
        start  = rx_accepted;
        while (rx_accepted - start < budget) begin
            kind = long_due ? 4 : $urandom_range(0, 15);
            if (kind == 0) begin
                // Noise, which may hit a marker.
                send_plain(BYTE_W'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                // Stray or repeated end marker.
                send_plain(mir_end);
            end else begin
                // Full-length frames overflow the store when extra bytes follow.
                if (long_due || $urandom_range(0, 31) == 0) begin
                    len   = STORE_CAP - 1;
                    extra = long_due ? $urandom_range(1, 6) : $urandom_range(0, 6);
                    long_due = 1'b0;
                end else begin
                    len   = $urandom_range(1, 8);
                    extra = 0;
                end
                send_plain(mir_begin);
                sum = '0;
                repeat (len) begin
                    b0  = plain_byte();
                    sum = sum + b0;
                    send_plain(b0);
                end
                // Kind 2 breaks the checksum, kind 3 leaves the frame open.
                if (kind == 2) begin
                    sum = sum + BYTE_W'($urandom_range(1, 255));
                end
                send_plain(sum);
                repeat (extra) send_plain(plain_byte());
                if (kind != 3) begin
                    send_plain(mir_end);
                end
            end
        end
    endtask

    // Watchdog on cycles with no request accepted on any channel.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_valid && !o_rx_stall) || (o_pl_valid && !pl_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: watchdog expired", $time);
        $display("TB_ERROR");
        $finish;
    end

    // Reset, directed table, random phases, then the verdict.
    initial begin : main_seq
        int  directed_items;
        bit  first;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rx_valid  = 1'b0;
        rx_byte   = '0;
        pl_stall  = 1'b0;
        mir_begin = BEGIN_MARKER_RST;
        mir_end   = END_MARKER_RST;
        mir_count = 0;
        mir_open  = 1'b0;
        mir_ovf   = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_CFG) begin
                write_reg(dir_table[r].idx, dir_table[r].val);
            end else begin
                send_rx(dir_table[r].val, dir_table[r].typed, dir_table[r].n_typed,
                        dir_table[r].rec);
            end
        end

        directed_items = rx_accepted;
        first = 1'b1;
        while ((rx_accepted - directed_items) < RANDOM_ITEMS) begin
            run_random_phase(first, directed_items);
            first = 1'b0;
        end

        settle();
        if (pending_payload_q.size() != 0) begin
            $display("%0t: %0d expected payload bytes never arrived", $time,
                     pending_payload_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> delimited_frame_receiver_unit.f
+incdir+hdl
hdl/dfr_pkg.sv
hdl/dfr_front.sv
hdl/dfr_cmd_queue.sv
hdl/dfr_back.sv
hdl/delimited_frame_receiver_unit.sv
verif/tb_top.sv
